// ===== rtl/plwa_pkg.sv =====
// package for the priority lock waiter arbiter
// holds the transfer payload types, status and mode codes and the sequencer states
// no dependencies
package plwa_pkg;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_FREED   = 3'd3,
        ST_HANDED  = 3'd4
    } status_t;

    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [5:0] requester;
        logic [7:0] prio;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [5:0] handed_to;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACQ_SWEEP,
        S_ACQ_WRITE,
        S_REL_SCAN,
        S_REL_DEC,
        S_DONE
    } state_t;

endpackage

// ===== rtl/plwa_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module plwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/priority_lock_waiter_arbiter_unit.sv =====
// priority lock waiter arbiter, top level
// depends on plwa_pkg and plwa_ram
//
// manages one lock with a table of up to WAITERS queued requesters.
// input channel s_valid/s_ready/s_item: mode 0 acquires for requester at prio,
// mode 1 releases. result channel m_valid/m_ready/m_item: one transfer per
// input with status granted, queued, full (dropped), freed or handed over,
// plus the new owner id when handed over.
// timing: a grant, a full drop or a release with no waiters shows its result
// without a ram sweep. a queued acquire sweeps the waiter ram once to age
// the other waiters and find the lowest free slot, then writes the new waiter.
// a handover sweeps the ram twice (pick the best waiter, then close the age
// gap). the single ram port pair sets the length of these sweeps.
// one item is worked on at a time; the next input is taken once the block is
// back in idle, even while a result still waits in the output register. if the
// receiver stalls, the finished result holds until the output register frees
// up. reset clears the lock and all valid marks; the waiter ram needs no
// clearing pass.
module priority_lock_waiter_arbiter_unit #(
    parameter int WAITERS   = 64,
    parameter int PRIO_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plwa_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output plwa_pkg::out_item_t m_item
);
    import plwa_pkg::*;

    localparam int IDX_W = $clog2(WAITERS);
    localparam int DW    = 6 + PRIO_BITS + IDX_W;
    localparam logic [IDX_W:0] END_CNT = (IDX_W + 1)'(WAITERS);

    state_t                 state_reg, state_next;
    logic [IDX_W:0]         cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pidx_reg, pidx_next;
    logic                   lock_reg, lock_next;
    logic [WAITERS-1:0]     valid_reg, valid_next;
    logic [IDX_W:0]         count_reg, count_next;
    logic [5:0]             who_reg, who_next;
    logic [PRIO_BITS-1:0]   prio_reg, prio_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       sel_idx_reg, sel_idx_next;
    logic [PRIO_BITS-1:0]   best_prio_reg, best_prio_next;
    logic [IDX_W-1:0]       best_age_reg, best_age_next;
    logic [5:0]             best_id_reg, best_id_next;
    status_t                res_status_reg, res_status_next;
    logic [5:0]             res_handed_reg, res_handed_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              out_reg, out_next;

    logic                   accept;
    logic                   sweeping;
    logic                   sweep_done;
    logic                   out_free;
    logic [PRIO_BITS+7:0]   prio_wide;
    logic [PRIO_BITS-1:0]   prio_in;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [DW-1:0]          ram_wdata;
    logic [DW-1:0]          ram_rdata;
    logic [5:0]             rd_id;
    logic [PRIO_BITS-1:0]   rd_prio;
    logic [IDX_W-1:0]       rd_age;
    logic                   rd_valid;

    plwa_ram #(
        .WIDTH(DW),
        .DEPTH(WAITERS)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(cnt_reg[IDX_W-1:0]),
        .rd_data(ram_rdata)
    );

    assign rd_age   = ram_rdata[IDX_W-1:0];
    assign rd_prio  = ram_rdata[IDX_W +: PRIO_BITS];
    assign rd_id    = ram_rdata[IDX_W + PRIO_BITS +: 6];
    assign rd_valid = valid_reg[pidx_reg];

    assign prio_wide = {{PRIO_BITS{1'b0}}, s_item.prio};
    assign prio_in   = prio_wide[PRIO_BITS-1:0];

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign sweeping   = (state_reg == S_ACQ_SWEEP) || (state_reg == S_REL_SCAN)
                        || (state_reg == S_REL_DEC);
    assign sweep_done = (cnt_reg == END_CNT) && !pend_reg;
    assign out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_item.mode == MODE_ACQUIRE) begin
                        if (lock_reg && (count_reg != END_CNT)) begin
                            state_next = S_ACQ_SWEEP;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else begin
                        if (count_reg != '0) begin
                            state_next = S_REL_SCAN;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_ACQ_SWEEP: begin
                if (sweep_done) begin
                    state_next = S_ACQ_WRITE;
                end
            end
            S_ACQ_WRITE: state_next = S_DONE;
            S_REL_SCAN: begin
                if (sweep_done) begin
                    state_next = S_REL_DEC;
                end
            end
            S_REL_DEC: begin
                if (sweep_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        lock_next       = lock_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        who_next        = who_reg;
        prio_next       = prio_reg;
        found_next      = found_reg;
        sel_idx_next    = sel_idx_reg;
        best_prio_next  = best_prio_reg;
        best_age_next   = best_age_reg;
        best_id_next    = best_id_reg;
        res_status_next = res_status_reg;
        res_handed_next = res_handed_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = pidx_reg;
        ram_wdata       = ram_rdata;

        // read issue for all sweeps
        if (sweeping && (cnt_reg != END_CNT)) begin
            cnt_next  = cnt_reg + 1'b1;
            pend_next = 1'b1;
            pidx_next = cnt_reg[IDX_W-1:0];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    who_next        = s_item.requester;
                    prio_next       = prio_in;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    res_handed_next = '0;
                    if (s_item.mode == MODE_ACQUIRE) begin
                        if (!lock_reg) begin
                            lock_next       = 1'b1;
                            res_status_next = ST_GRANTED;
                        end else if (count_reg == END_CNT) begin
                            res_status_next = ST_FULL;
                        end
                    end else if (count_reg == '0) begin
                        lock_next       = 1'b0;
                        res_status_next = ST_FREED;
                    end
                end
            end
            S_ACQ_SWEEP: begin
                if (pend_reg) begin
                    if (rd_valid) begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_id, rd_prio, rd_age + 1'b1};
                    end else if (!found_reg) begin
                        found_next   = 1'b1;
                        sel_idx_next = pidx_reg;
                    end
                end
            end
            S_ACQ_WRITE: begin
                ram_we                  = 1'b1;
                ram_waddr               = sel_idx_reg;
                ram_wdata               = {who_reg, prio_reg, {IDX_W{1'b0}}};
                valid_next[sel_idx_reg] = 1'b1;
                count_next              = count_reg + 1'b1;
                res_status_next         = ST_QUEUED;
            end
            S_REL_SCAN: begin
                if (pend_reg && rd_valid) begin
                    if (!found_reg || (rd_prio > best_prio_reg)
                        || ((rd_prio == best_prio_reg) && (rd_age < best_age_reg))) begin
                        found_next     = 1'b1;
                        sel_idx_next   = pidx_reg;
                        best_prio_next = rd_prio;
                        best_age_next  = rd_age;
                        best_id_next   = rd_id;
                    end
                end
                if (sweep_done) begin
                    cnt_next = '0;
                end
            end
            S_REL_DEC: begin
                if (pend_reg && rd_valid && (rd_age > best_age_reg)) begin
                    ram_we    = 1'b1;
                    ram_wdata = {rd_id, rd_prio, rd_age - 1'b1};
                end
                if (sweep_done) begin
                    valid_next[sel_idx_reg] = 1'b0;
                    count_next              = count_reg - 1'b1;
                    lock_next               = 1'b1;
                    res_status_next         = ST_HANDED;
                    res_handed_next         = best_id_reg;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    out_next.status    = res_status_reg;
                    out_next.handed_to = res_handed_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            lock_reg    <= 1'b0;
            valid_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            lock_reg    <= lock_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        pidx_reg       <= pidx_next;
        who_reg        <= who_next;
        prio_reg       <= prio_next;
        found_reg      <= found_next;
        sel_idx_reg    <= sel_idx_next;
        best_prio_reg  <= best_prio_next;
        best_age_reg   <= best_age_next;
        best_id_reg    <= best_id_next;
        res_status_reg <= res_status_next;
        res_handed_reg <= res_handed_next;
        out_reg        <= out_next;
    end

endmodule

// ===== verif/priority_lock_waiter_arbiter_unit_tb.sv =====
// testbench for priority_lock_waiter_arbiter_unit: directed lock sequences, then random traffic
// results are predicted from a behavioural copy of the lock and wait table and checked per transfer
// depends on plwa_pkg and the rtl of the block
module priority_lock_waiter_arbiter_unit_tb;
    import plwa_pkg::*;

    localparam int WAITERS      = 64;
    localparam int LIMIT_CYCLES = 1_500_000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // predicted lock and wait table
    bit         lock_taken;
    bit         slot_used [WAITERS];
    logic [5:0] slot_owner[WAITERS];
    logic [7:0] slot_prio [WAITERS];
    int         slot_age  [WAITERS];
    int         waiter_count;

    out_item_t  outcomes_due[$];
    out_item_t  oldest_due;
    int         mismatch_count;
    int         cycle_count;
    bit         idle_on;
    int         hold_request;
    bit         hold_taken;
    int         stall_left;

    priority_lock_waiter_arbiter_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever begin
            #2 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("priority_lock_waiter_arbiter_unit_tb failed");
            $finish;
        end
    end

    function automatic out_item_t lock_outcome(in_item_t it);
        out_item_t r;
        int free_slot;
        int best;
        r.status    = ST_GRANTED;
        r.handed_to = '0;
        free_slot   = -1;
        best        = -1;
        if (it.mode == MODE_ACQUIRE) begin
            if (!lock_taken) begin
                lock_taken = 1'b1;
                r.status   = ST_GRANTED;
            end else begin
                for (int i = 0; i < WAITERS; i++) begin
                    if (!slot_used[i] && free_slot < 0) free_slot = i;
                end
                if (free_slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = 0; i < WAITERS; i++) begin
                        if (slot_used[i]) slot_age[i]++;
                    end
                    slot_used[free_slot]  = 1'b1;
                    slot_owner[free_slot] = it.requester;
                    slot_prio[free_slot]  = it.prio;
                    slot_age[free_slot]   = 0;
                    waiter_count++;
                    r.status = ST_QUEUED;
                end
            end
        end else begin
            for (int i = 0; i < WAITERS; i++) begin
                if (slot_used[i] && (best < 0 || slot_prio[i] > slot_prio[best] ||
                    (slot_prio[i] == slot_prio[best] && slot_age[i] < slot_age[best])))
                    best = i;
            end
            if (best < 0) begin
                lock_taken = 1'b0;
                r.status   = ST_FREED;
            end else begin
                for (int i = 0; i < WAITERS; i++) begin
                    if (slot_used[i] && slot_age[i] > slot_age[best]) slot_age[i]--;
                end
                slot_used[best] = 1'b0;
                waiter_count--;
                lock_taken  = 1'b1;
                r.status    = ST_HANDED;
                r.handed_to = slot_owner[best];
            end
        end
        return r;
    endfunction

    task automatic send_transfer(input logic mode, input logic [5:0] who, input logic [7:0] pr);
        in_item_t it;
        int gap;
        it.mode      = mode;
        it.requester = who;
        it.prio      = pr;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        outcomes_due.push_back(lock_outcome(it));
    endtask

    function automatic logic [7:0] pick_prio(int span);
        case (span)
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(0, 3));
            default: begin
                case ($urandom_range(0, 2))
                    0: return 8'd0;
                    1: return 8'd255;
                    default: return 8'd128;
                endcase
            end
        endcase
    endfunction

    // receiver side: short random stalls, or one long hold when asked
    initial begin
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0 && !hold_taken) begin
                stall_left = hold_request;
                hold_taken = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (outcomes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: status %0d handed_to %0d",
                             m_item.status, m_item.handed_to);
            end else begin
                oldest_due = outcomes_due.pop_front();
                if (m_item.status !== oldest_due.status ||
                    m_item.handed_to !== oldest_due.handed_to) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d/%0d, got %0d/%0d (status/handed_to)",
                                 oldest_due.status, oldest_due.handed_to,
                                 m_item.status, m_item.handed_to);
                end
            end
        end
    end

    task automatic test_grant_and_free();
        send_transfer(MODE_RELEASE, 6'd0, 8'd0);
        send_transfer(MODE_ACQUIRE, 6'd0, 8'd0);
        send_transfer(MODE_RELEASE, 6'd63, 8'd255);
        send_transfer(MODE_RELEASE, 6'd63, 8'd255);
    endtask

    task automatic test_handover_order();
        send_transfer(MODE_ACQUIRE, 6'd63, 8'd255);
        send_transfer(MODE_ACQUIRE, 6'd5, 8'd10);
        send_transfer(MODE_ACQUIRE, 6'd6, 8'd255);
        send_transfer(MODE_ACQUIRE, 6'd7, 8'd10);
        // owner asks again, gets queued
        send_transfer(MODE_ACQUIRE, 6'd63, 8'd0);
        send_transfer(MODE_ACQUIRE, 6'd0, 8'd255);
        repeat (6) send_transfer(MODE_RELEASE, 6'd42, 8'd170);
    endtask

    task automatic test_table_full();
        send_transfer(MODE_ACQUIRE, 6'd21, 8'd1);
        while (waiter_count < WAITERS)
            send_transfer(MODE_ACQUIRE, 6'($urandom_range(0, 63)), pick_prio($urandom_range(0, 2)));
        send_transfer(MODE_ACQUIRE, 6'd63, 8'd255);
        send_transfer(MODE_ACQUIRE, 6'd0, 8'd0);
        while (lock_taken)
            send_transfer(MODE_RELEASE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_backpressure();
        hold_request = 400;
        repeat (30)
            send_transfer(logic'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                          pick_prio(0));
    endtask

    task automatic random_traffic(input int items, input bit allow_idle);
        int left;
        int run;
        int acq_pct;
        int span;
        left = items;
        while (left > 0) begin
            run = $urandom_range(40, 120);
            if (run > left) run = left;
            case ($urandom_range(0, 3))
                0: acq_pct = 30;
                1: acq_pct = 50;
                2: acq_pct = 70;
                default: acq_pct = 90;
            endcase
            span    = $urandom_range(0, 2);
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            repeat (run) begin
                if ($urandom_range(0, 99) < acq_pct)
                    send_transfer(MODE_ACQUIRE, 6'($urandom_range(0, 63)), pick_prio(span));
                else
                    send_transfer(MODE_RELEASE, 6'($urandom_range(0, 63)),
                                  8'($urandom_range(0, 255)));
            end
            left -= run;
        end
    endtask

    task automatic test_random_mix();
        random_traffic(1600, 1'b1);
    endtask

    task automatic test_calm_tail();
        random_traffic(170, 1'b0);
        idle_on = 1'b0;
    endtask

    initial begin
        idle_on        = 1'b1;
        hold_request   = 0;
        mismatch_count = 0;
        lock_taken     = 1'b0;
        waiter_count   = 0;
        for (int i = 0; i < WAITERS; i++) slot_used[i] = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_grant_and_free();
        test_handover_order();
        test_table_full();
        test_backpressure();
        test_random_mix();
        test_calm_tail();
        s_valid <= 1'b0;
        wait (outcomes_due.size() == 0);
        repeat (2 * WAITERS + 10) @(posedge aclk);
        if (mismatch_count == 0 && outcomes_due.size() == 0) begin
            $display("priority_lock_waiter_arbiter_unit_tb passed");
        end else begin
            $display("priority_lock_waiter_arbiter_unit_tb failed");
        end
        $finish;
    end

endmodule
